// ===== rtl/pcm_integer_rate_scaler_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the PCM integer rate scaler
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PCM_INTEGER_RATE_SCALER_CORE_ASSERT_SVH
`define PCM_INTEGER_RATE_SCALER_CORE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define PIRS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PIRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pirs_pkg.sv =====
// ----------------------------------------------------------------------------
// PCM integer rate scaler package
// Shared constants, register indexes and controller/datapath structs.
// ----------------------------------------------------------------------------
package pirs_pkg;

  localparam int N_CH           = 6;
  localparam int SMP_BITS       = 24;
  localparam int DEF_MAX_FACTOR = 16;
  localparam int MIN_FACTOR     = 2;
  localparam int FACTOR_BITS    = 5;
  localparam int CH_BITS        = 3;
  localparam int CH_IDX_BITS    = $clog2(N_CH);
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 5;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MODE     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FACTOR   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNELS = 2'd2;

  localparam logic MODE_DECIMATE = 1'b0;
  localparam logic MODE_REPEAT   = 1'b1;

  localparam logic                   RST_MODE     = MODE_DECIMATE;
  localparam logic [FACTOR_BITS-1:0] RST_FACTOR   = 5'd2;
  localparam logic [CH_BITS-1:0]     RST_CHANNELS = 3'd2;

  typedef struct packed {
    logic                   in_ready;
    logic                   acc_add;
    logic                   grp_clear;
    logic                   frame_load;
    logic                   div_start;
    logic                   q_store;
    logic                   q_zero;
    logic                   out_load_avg;
    logic                   out_load_rep;
    logic                   rep_last;
    logic [CH_IDX_BITS-1:0] ch;
  } pirs_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic grp_close;
    logic out_free;
    logic div_done;
  } pirs_sts_t;

endpackage

// ===== rtl/pirs_stream_if.sv =====
// ----------------------------------------------------------------------------
// PCM integer rate scaler stream interfaces
// Valid/ready channels for input frames and result frames.
// ----------------------------------------------------------------------------
interface pirs_in_if;
  import pirs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SMP_BITS-1:0] sample_0;
  logic signed [SMP_BITS-1:0] sample_1;
  logic signed [SMP_BITS-1:0] sample_2;
  logic signed [SMP_BITS-1:0] sample_3;
  logic signed [SMP_BITS-1:0] sample_4;
  logic signed [SMP_BITS-1:0] sample_5;
  logic                       last_frame;

  modport source (
    output valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5, last_frame,
    input  ready
  );
  modport sink (
    input  valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5, last_frame,
    output ready
  );
endinterface

interface pirs_out_if;
  import pirs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SMP_BITS-1:0] out_0;
  logic signed [SMP_BITS-1:0] out_1;
  logic signed [SMP_BITS-1:0] out_2;
  logic signed [SMP_BITS-1:0] out_3;
  logic signed [SMP_BITS-1:0] out_4;
  logic signed [SMP_BITS-1:0] out_5;
  logic                       last_of_run;

  modport source (
    output valid, out_0, out_1, out_2, out_3, out_4, out_5, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, out_0, out_1, out_2, out_3, out_4, out_5, last_of_run,
    output ready
  );
endinterface

// ===== rtl/pirs_div.sv =====
// ----------------------------------------------------------------------------
// PCM integer rate scaler serial divider
// Signed restoring divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module pirs_div #(
  parameter int ACC_W = 28,
  parameter int DVS_W = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [ACC_W-1:0]             dividend,
  input  logic        [DVS_W-1:0]             divisor,
  output logic                                done,
  output logic signed [pirs_pkg::SMP_BITS-1:0] quot
);
  import pirs_pkg::*;

  localparam int SW = $clog2(ACC_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             neg_r, neg_nxt;
  logic [ACC_W-1:0] qr_r, qr_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [SW-1:0]    step_r, step_nxt;

  logic [ACC_W-1:0] dvd_u;
  logic [ACC_W-1:0] mag;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             ge;
  logic [ACC_W-1:0] qfix;

  assign dvd_u   = $unsigned(dividend);
  assign mag     = dvd_u[ACC_W-1] ? (~dvd_u + ACC_W'(1)) : dvd_u;
  assign rem_sh  = {rem_r, qr_r[ACC_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign ge      = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    qr_nxt   = qr_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    if (start) begin
      busy_nxt = 1'b1;
      neg_nxt  = dvd_u[ACC_W-1];
      qr_nxt   = mag;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      step_nxt = '0;
    end else if (busy_r) begin
      qr_nxt   = {qr_r[ACC_W-2:0], ge};
      rem_nxt  = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      step_nxt = step_r + SW'(1);
      if (step_r == SW'(ACC_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    qr_r   <= qr_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    step_r <= step_nxt;
  end

  assign qfix = neg_r ? (~qr_r + ACC_W'(1)) : qr_r;
  assign quot = $signed(qfix[SMP_BITS-1:0]);
  assign done = done_r;

endmodule

// ===== rtl/pirs_dp.sv =====
// ----------------------------------------------------------------------------
// PCM integer rate scaler datapath
// Channel accumulators, frame count, held frame, quotients and result register.
// ----------------------------------------------------------------------------
module pirs_dp #(
  parameter int MAX_FACTOR = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [$clog2(MAX_FACTOR+1)-1:0] eff_f,
  input  logic [pirs_pkg::CH_BITS-1:0] nch,
  input  pirs_pkg::pirs_cmd_t          cmd,
  output pirs_pkg::pirs_sts_t          sts,
  pirs_in_if.sink                      in_if,
  pirs_out_if.source                   out_if
);
  import pirs_pkg::*;

  localparam int FW    = $clog2(MAX_FACTOR + 1);
  localparam int ACC_W = SMP_BITS + $clog2(MAX_FACTOR);

  logic signed [SMP_BITS-1:0] in_smp [N_CH];

  logic signed [ACC_W-1:0]    sum_r [N_CH];
  logic signed [ACC_W-1:0]    sum_nxt [N_CH];
  logic [FW-1:0]              cnt_r, cnt_nxt;
  logic [FW-1:0]              cnt_inc;
  logic signed [SMP_BITS-1:0] frame_r [N_CH];
  logic signed [SMP_BITS-1:0] frame_nxt [N_CH];
  logic signed [SMP_BITS-1:0] q_r [N_CH];
  logic signed [SMP_BITS-1:0] q_nxt [N_CH];
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SMP_BITS-1:0] out_smp_r [N_CH];
  logic signed [SMP_BITS-1:0] out_smp_nxt [N_CH];
  logic                       out_last_r, out_last_nxt;

  logic                       div_done;
  logic signed [SMP_BITS-1:0] div_q;

  assign in_smp[0] = in_if.sample_0;
  assign in_smp[1] = in_if.sample_1;
  assign in_smp[2] = in_if.sample_2;
  assign in_smp[3] = in_if.sample_3;
  assign in_smp[4] = in_if.sample_4;
  assign in_smp[5] = in_if.sample_5;

  assign cnt_inc = cnt_r + FW'(1);

  pirs_div #(
    .ACC_W (ACC_W),
    .DVS_W (FW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_r[cmd.ch]),
    .divisor  (eff_f),
    .done     (div_done),
    .quot     (div_q)
  );

  always_comb begin
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    frame_nxt     = frame_r;
    q_nxt         = q_r;
    out_smp_nxt   = out_smp_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;

    if (cmd.acc_add) begin
      for (int c = 0; c < N_CH; c++) begin
        if (c < int'(nch)) begin
          sum_nxt[c] = sum_r[c] + ACC_W'(in_smp[c]);
        end
      end
      cnt_nxt = cnt_inc;
    end
    if (cmd.grp_clear) begin
      for (int c = 0; c < N_CH; c++) begin
        sum_nxt[c] = '0;
      end
      cnt_nxt = '0;
    end

    if (cmd.frame_load) begin
      for (int c = 0; c < N_CH; c++) begin
        frame_nxt[c] = (c < int'(nch)) ? in_smp[c] : '0;
      end
    end

    if (cmd.q_store) begin
      q_nxt[cmd.ch] = cmd.q_zero ? '0 : div_q;
    end

    if (cmd.out_load_avg) begin
      out_smp_nxt   = q_r;
      out_last_nxt  = 1'b1;
      out_valid_nxt = 1'b1;
    end else if (cmd.out_load_rep) begin
      out_smp_nxt   = frame_r;
      out_last_nxt  = cmd.rep_last;
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < N_CH; c++) begin
        sum_r[c] <= '0;
      end
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r    <= frame_nxt;
    q_r        <= q_nxt;
    out_smp_r  <= out_smp_nxt;
    out_last_r <= out_last_nxt;
  end

  assign sts.in_valid  = in_if.valid;
  assign sts.in_last   = in_if.last_frame;
  assign sts.grp_close = (cnt_inc >= eff_f);
  assign sts.out_free  = !out_valid_r || out_if.ready;
  assign sts.div_done  = div_done;

  assign in_if.ready        = cmd.in_ready;
  assign out_if.valid       = out_valid_r;
  assign out_if.out_0       = out_smp_r[0];
  assign out_if.out_1       = out_smp_r[1];
  assign out_if.out_2       = out_smp_r[2];
  assign out_if.out_3       = out_smp_r[3];
  assign out_if.out_4       = out_smp_r[4];
  assign out_if.out_5       = out_smp_r[5];
  assign out_if.last_of_run = out_last_r;

endmodule

// ===== rtl/pirs_ctrl.sv =====
// ----------------------------------------------------------------------------
// PCM integer rate scaler controller
// Sequences accumulation, per-channel division and result frame loading.
// ----------------------------------------------------------------------------
`include "pcm_integer_rate_scaler_core_assert.svh"

module pirs_ctrl #(
  parameter int MAX_FACTOR = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            mode,
  input  logic [$clog2(MAX_FACTOR+1)-1:0] eff_f,
  input  logic [pirs_pkg::CH_BITS-1:0]    nch,
  input  pirs_pkg::pirs_sts_t             sts,
  output pirs_pkg::pirs_cmd_t             cmd
);
  import pirs_pkg::*;

  localparam int FW = $clog2(MAX_FACTOR + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_START,
    S_DIV_WAIT,
    S_AVG_OUT,
    S_REP_OUT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CH_IDX_BITS-1:0] ch_r, ch_nxt;
  logic [FW-1:0]          copy_r, copy_nxt;
  logic                   ch_last;

  assign ch_last = (ch_r == CH_IDX_BITS'(N_CH - 1));

  always_comb begin
    cmd       = '0;
    cmd.ch    = ch_r;
    state_nxt = state_r;
    ch_nxt    = ch_r;
    copy_nxt  = copy_r;
    case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          if (mode == MODE_REPEAT) begin
            cmd.frame_load = 1'b1;
            cmd.grp_clear  = sts.in_last;
            copy_nxt       = '0;
            state_nxt      = S_REP_OUT;
          end else begin
            cmd.acc_add = 1'b1;
            if (sts.grp_close) begin
              ch_nxt    = '0;
              state_nxt = S_DIV_START;
            end else begin
              cmd.grp_clear = sts.in_last;
            end
          end
        end
      end
      S_DIV_START: begin
        if (int'(ch_r) < int'(nch)) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV_WAIT;
        end else begin
          cmd.q_store = 1'b1;
          cmd.q_zero  = 1'b1;
          if (ch_last) begin
            state_nxt = S_AVG_OUT;
          end else begin
            ch_nxt = ch_r + CH_IDX_BITS'(1);
          end
        end
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.q_store = 1'b1;
          if (ch_last) begin
            state_nxt = S_AVG_OUT;
          end else begin
            ch_nxt    = ch_r + CH_IDX_BITS'(1);
            state_nxt = S_DIV_START;
          end
        end
      end
      S_AVG_OUT: begin
        if (sts.out_free) begin
          cmd.out_load_avg = 1'b1;
          cmd.grp_clear    = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_REP_OUT: begin
        if (sts.out_free) begin
          cmd.out_load_rep = 1'b1;
          cmd.rep_last     = ((copy_r + FW'(1)) == eff_f);
          if (cmd.rep_last) begin
            state_nxt = S_IDLE;
          end else begin
            copy_nxt = copy_r + FW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= '0;
      copy_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      copy_r  <= copy_nxt;
    end
  end

  `PIRS_ASSERT_NEXT(a_div_wait_hold, (state_r == S_DIV_WAIT) && !sts.div_done, state_r == S_DIV_WAIT, "controller left divide wait without a quotient")
  `PIRS_ASSERT_NEXT(a_avg_to_idle, cmd.out_load_avg, state_r == S_IDLE, "controller did not return to idle after the averaged frame")
  `PIRS_ASSERT_NEXT(a_close_starts_div, cmd.acc_add && sts.grp_close, (state_r == S_DIV_START) && (ch_r == '0), "closed group did not start division at the first channel")
  `PIRS_ASSERT_SAME(a_rep_last_on_load, cmd.rep_last, cmd.out_load_rep && (state_r == S_REP_OUT), "last-of-run flag raised without a repeat load")

endmodule

// ===== rtl/pcm_integer_rate_scaler_core.sv =====
// ----------------------------------------------------------------------------
// PCM integer rate scaler core
// Boxcar decimator and sample-repeat interpolator for six-channel PCM frames.
// ----------------------------------------------------------------------------
// Frames enter on in_if and results leave on out_if, both valid/ready; a
// request moves when valid and ready are high at a rising edge. Registers
// mode, factor and channels are written through cfg_we/cfg_index/cfg_wdata;
// the user must write them only while the block is idle, as the block does
// not enforce it. In decimate mode a frame that does not close its group is
// taken and the next frame may follow at once. A frame that closes the group
// is divided channel by channel in one shared serial divider of ACC_W =
// SMP_BITS + log2(MAX_FACTOR) steps; each unused channel gets a zero
// quotient, and then the averaged frame is loaded into the result register.
// In repeat mode the factor copies leave one per cycle while the receiver
// keeps up, and the next frame is taken after the last copy is loaded. Reset
// clears the accumulators, the frame count and the output valid flag and
// restores mode 0, factor 2 and two channels. When the receiver stalls, the
// result register holds its frame and the block waits before loading the
// next one; input is not taken meanwhile.
// ----------------------------------------------------------------------------
module pcm_integer_rate_scaler_core #(
  parameter int MAX_FACTOR = pirs_pkg::DEF_MAX_FACTOR
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pirs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [pirs_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  pirs_in_if.sink                            in_if,
  pirs_out_if.source                         out_if
);
  import pirs_pkg::*;

  localparam int FW = $clog2(MAX_FACTOR + 1);
  localparam int CW = (FW > FACTOR_BITS) ? FW : FACTOR_BITS;

  logic                   mode_r, mode_nxt;
  logic [FACTOR_BITS-1:0] factor_r, factor_nxt;
  logic [CH_BITS-1:0]     chans_r, chans_nxt;

  logic [CW-1:0]          factor_ext;
  logic [FW-1:0]          eff_f;
  logic [CH_BITS-1:0]     nch;

  pirs_cmd_t              cmd;
  pirs_sts_t              sts;

  always_comb begin
    mode_nxt   = mode_r;
    factor_nxt = factor_r;
    chans_nxt  = chans_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:     mode_nxt   = cfg_wdata[0];
        CFG_FACTOR:   factor_nxt = cfg_wdata[FACTOR_BITS-1:0];
        CFG_CHANNELS: chans_nxt  = cfg_wdata[CH_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= RST_MODE;
      factor_r <= RST_FACTOR;
      chans_r  <= RST_CHANNELS;
    end else begin
      mode_r   <= mode_nxt;
      factor_r <= factor_nxt;
      chans_r  <= chans_nxt;
    end
  end

  assign factor_ext = CW'(factor_r);

  always_comb begin
    if (factor_ext < CW'(MIN_FACTOR)) begin
      eff_f = FW'(MIN_FACTOR);
    end else if (factor_ext > CW'(MAX_FACTOR)) begin
      eff_f = FW'(MAX_FACTOR);
    end else begin
      eff_f = FW'(factor_ext);
    end
  end

  always_comb begin
    if (chans_r == '0) begin
      nch = CH_BITS'(1);
    end else if (chans_r > CH_BITS'(N_CH)) begin
      nch = CH_BITS'(N_CH);
    end else begin
      nch = chans_r;
    end
  end

  pirs_ctrl #(
    .MAX_FACTOR (MAX_FACTOR)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .mode  (mode_r),
    .eff_f (eff_f),
    .nch   (nch),
    .sts   (sts),
    .cmd   (cmd)
  );

  pirs_dp #(
    .MAX_FACTOR (MAX_FACTOR)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .eff_f  (eff_f),
    .nch    (nch),
    .cmd    (cmd),
    .sts    (sts),
    .in_if  (in_if),
    .out_if (out_if)
  );

endmodule

// ===== tb/tb_pcm_integer_rate_scaler_core.sv =====
// ----------------------------------------------------------------------------
// Testbench for the PCM integer rate scaler core
// Drives multichannel PCM frames through the valid/ready input channel while
// a clocked monitor compares every result frame with a frame-by-frame
// prediction of the averaging decimator and the sample-repeat interpolator.
// Register settings change between traffic phases, including out-of-range
// factor and channel counts, stream ends and factor changes inside a group.
// Both channels idle at random, and one phase holds off the receiver long
// enough that the core must stall its input.
// ----------------------------------------------------------------------------
module tb_pcm_integer_rate_scaler_core;
  import pirs_pkg::*;

  localparam int          SETTLE_CYCLES = 200;
  localparam int          LONG_HOLD     = 300;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
  localparam logic [SMP_BITS-1:0]     SMP_MAX   = 24'h7FFFFF;
  localparam logic [SMP_BITS-1:0]     SMP_MIN   = 24'h800000;

  typedef struct packed {
    logic [N_CH-1:0][SMP_BITS-1:0] smp;
    logic                          last;
  } pcm_frame_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  pirs_in_if  frame_ch ();
  pirs_out_if result_ch ();

  pcm_integer_rate_scaler_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_if     (frame_ch.sink),
    .out_if    (result_ch.source)
  );

  always #6 clk = ~clk;

  // Register copies and group state of the scaler as predicted.
  logic                   mode_reg;
  logic [FACTOR_BITS-1:0] factor_reg;
  logic [CH_BITS-1:0]     channels_reg;
  longint                 channel_acc [N_CH];
  int                     group_count;

  pcm_frame_t  pending_frames [$];
  pcm_frame_t  expected_frames [$];
  pcm_frame_t  offered_frame;
  pcm_frame_t  observed;

  int unsigned frames_queued;
  int unsigned frames_taken;
  int unsigned results_checked;
  int unsigned groups_emitted;
  int unsigned groups_dropped;
  int unsigned frames_repeated;
  int unsigned settings_used;
  int unsigned errors;
  int unsigned cycle_count;

  int unsigned source_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned source_gap;
  int unsigned sink_stall;
  int unsigned sink_gap;
  int unsigned hold_requests;
  int unsigned hold_served;

  assign observed = {result_ch.out_5, result_ch.out_4, result_ch.out_3, result_ch.out_2,
                     result_ch.out_1, result_ch.out_0, result_ch.last_of_run};

  function automatic int unsigned idle_length(input int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  function automatic void clear_group();
    for (int c = 0; c < N_CH; c++) channel_acc[c] = 0;
    group_count = 0;
  endfunction

  // Works out the result frames that one accepted input frame causes.
  function automatic void scale_frame(input pcm_frame_t fr);
    int         fac;
    int         nch;
    longint     quot;
    pcm_frame_t res;
    fac = int'(factor_reg);
    if (fac < MIN_FACTOR) fac = MIN_FACTOR;
    else if (fac > DEF_MAX_FACTOR) fac = DEF_MAX_FACTOR;
    nch = int'(channels_reg);
    if (nch < 1) nch = 1;
    else if (nch > N_CH) nch = N_CH;
    if (mode_reg == MODE_REPEAT) begin
      for (int k = 0; k < fac; k++) begin
        for (int c = 0; c < N_CH; c++) res.smp[c] = (c < nch) ? fr.smp[c] : '0;
        res.last = (k == fac - 1);
        expected_frames.push_back(res);
      end
      frames_repeated++;
      if (fr.last) clear_group();
    end else begin
      for (int c = 0; c < nch; c++) channel_acc[c] += longint'(signed'(fr.smp[c]));
      group_count++;
      if (group_count >= fac) begin
        for (int c = 0; c < N_CH; c++) begin
          quot = (c < nch) ? channel_acc[c] / longint'(fac) : 0;
          res.smp[c] = quot[SMP_BITS-1:0];
        end
        res.last = 1'b1;
        expected_frames.push_back(res);
        groups_emitted++;
        clear_group();
      end else if (fr.last) begin
        groups_dropped++;
        clear_group();
      end
    end
  endfunction

  function automatic void check_result(input pcm_frame_t got);
    pcm_frame_t want;
    if (expected_frames.size() == 0) begin
      errors++;
      $display("%0t: result frame with none expected, got %p", $time, got);
      return;
    end
    want = expected_frames.pop_front();
    for (int c = 0; c < N_CH; c++) begin
      if (got.smp[c] !== want.smp[c]) begin
        errors++;
        $display("%0t: channel %0d expected %0d, got %0d", $time, c,
                 $signed(want.smp[c]), $signed(got.smp[c]));
      end
    end
    if (got.last !== want.last) begin
      errors++;
      $display("%0t: last_of_run expected %0b, got %0b", $time, want.last, got.last);
    end
    results_checked++;
  endfunction

  // Input driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      frame_ch.valid <= 1'b0;
      source_gap     <= 0;
    end else begin
      if (frame_ch.valid && frame_ch.ready) begin
        scale_frame(offered_frame);
        frames_taken++;
      end
      if (!frame_ch.valid || frame_ch.ready) begin
        if (source_gap > 0) begin
          source_gap     <= source_gap - 1;
          frame_ch.valid <= 1'b0;
        end else if (pending_frames.size() > 0) begin
          offered_frame        = pending_frames.pop_front();
          frame_ch.sample_0   <= offered_frame.smp[0];
          frame_ch.sample_1   <= offered_frame.smp[1];
          frame_ch.sample_2   <= offered_frame.smp[2];
          frame_ch.sample_3   <= offered_frame.smp[3];
          frame_ch.sample_4   <= offered_frame.smp[4];
          frame_ch.sample_5   <= offered_frame.smp[5];
          frame_ch.last_frame <= offered_frame.last;
          frame_ch.valid      <= 1'b1;
          source_gap          <= idle_length(source_idle_pct);
        end else begin
          frame_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      result_ch.ready <= 1'b0;
      sink_stall      <= 0;
      hold_served     <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) check_result(observed);
      if (hold_served != hold_requests) begin
        hold_served     <= hold_requests;
        sink_stall      <= LONG_HOLD;
        result_ch.ready <= 1'b0;
      end else if (sink_stall > 0) begin
        sink_stall      <= sink_stall - 1;
        result_ch.ready <= 1'b0;
      end else begin
        sink_gap = idle_length(sink_idle_pct);
        if (sink_gap > 0) begin
          sink_stall      <= sink_gap - 1;
          result_ch.ready <= 1'b0;
        end else begin
          result_ch.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout with %0d result frames outstanding", $time, expected_frames.size());
    $display("FAILURE");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MODE:     mode_reg     = val[0];
      CFG_FACTOR:   factor_reg   = val[FACTOR_BITS-1:0];
      CFG_CHANNELS: channels_reg = val[CH_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CFG_DATA_BITS-1:0] mode_v, factor_v, channels_v);
    write_reg(CFG_MODE, mode_v);
    write_reg(CFG_FACTOR, factor_v);
    write_reg(CFG_CHANNELS, channels_v);
    settings_used++;
  endtask

  task automatic send(input pcm_frame_t fr);
    pending_frames.push_back(fr);
    frames_queued++;
  endtask

  task automatic drain();
    while (frames_taken != frames_queued || expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic pcm_frame_t frame_of(input logic [SMP_BITS-1:0] s0, s1, rest,
                                          input logic last);
    pcm_frame_t fr;
    for (int c = 0; c < N_CH; c++) fr.smp[c] = rest;
    fr.smp[0] = s0;
    fr.smp[1] = s1;
    fr.last   = last;
    return fr;
  endfunction

  function automatic logic [SMP_BITS-1:0] random_sample();
    case ($urandom_range(19))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return '0;
      3:       return '1;
      default: return SMP_BITS'($urandom);
    endcase
  endfunction

  function automatic pcm_frame_t random_frame();
    pcm_frame_t fr;
    for (int c = 0; c < N_CH; c++) fr.smp[c] = random_sample();
    fr.last = ($urandom_range(99) < 6);
    return fr;
  endfunction

  initial begin
    int unsigned random_sent;
    int unsigned burst;
    logic [CFG_DATA_BITS-1:0] factor_v;

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_MODE;
    cfg_wdata          = '0;
    frame_ch.valid     = 1'b0;
    frame_ch.sample_0  = '0;
    frame_ch.sample_1  = '0;
    frame_ch.sample_2  = '0;
    frame_ch.sample_3  = '0;
    frame_ch.sample_4  = '0;
    frame_ch.sample_5  = '0;
    frame_ch.last_frame = 1'b0;
    result_ch.ready    = 1'b0;
    mode_reg           = RST_MODE;
    factor_reg         = RST_FACTOR;
    channels_reg       = RST_CHANNELS;
    clear_group();
    frames_queued      = 0;
    frames_taken       = 0;
    results_checked    = 0;
    groups_emitted     = 0;
    groups_dropped     = 0;
    frames_repeated    = 0;
    settings_used      = 0;
    errors             = 0;
    cycle_count        = 0;
    source_idle_pct    = 0;
    sink_idle_pct      = 0;
    hold_requests      = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: full-scale averages and truncation toward zero.
    set_config(MODE_DECIMATE, 5'd2, 5'd2);
    send(frame_of(SMP_MAX, SMP_MAX, SMP_MAX, 1'b0));
    send(frame_of(SMP_MAX, SMP_MAX, SMP_MAX, 1'b0));
    send(frame_of(SMP_MIN, SMP_MIN, SMP_MIN, 1'b0));
    send(frame_of(SMP_MIN, SMP_MIN, SMP_MIN, 1'b0));
    send(frame_of(24'(1), 24'(-2), SMP_MAX, 1'b0));
    send(frame_of(24'(-4), 24'(0), SMP_MIN, 1'b0));
    drain();

    // Factor and channel count below their ranges.
    set_config(MODE_DECIMATE, 5'd0, 5'd0);
    send(frame_of(24'h555555, 24'hAAAAAA, 24'h555555, 1'b0));
    send(frame_of(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 1'b0));
    drain();

    // Stream end with an incomplete group, then with a complete one.
    set_config(MODE_DECIMATE, 5'd4, 5'd7);
    send(frame_of(24'd1000, 24'(-1000), SMP_MAX, 1'b0));
    send(frame_of(24'd2000, 24'(-2000), SMP_MIN, 1'b0));
    send(frame_of(24'd3000, 24'(-3000), SMP_MAX, 1'b1));
    for (int i = 0; i < 4; i++) send(frame_of(24'(7 * i - 9), 24'(-5 * i), 24'(i), i == 3));
    drain();

    // Factor lowered while a group is open.
    write_reg(CFG_FACTOR, 5'd8);
    for (int i = 0; i < 3; i++) send(frame_of(24'(100 + i), 24'(-77), SMP_MAX, 1'b0));
    drain();
    write_reg(CFG_FACTOR, 5'd3);
    send(frame_of(24'(5), 24'(-1), SMP_MIN, 1'b0));
    drain();

    // A stream end in repeat mode clears an open averaging group.
    write_reg(CFG_FACTOR, 5'd2);
    send(frame_of(SMP_MAX, SMP_MIN, SMP_MAX, 1'b0));
    drain();
    set_config(MODE_REPEAT, 5'd1, 5'd3);
    send(frame_of(24'(-1), 24'(1), SMP_MIN, 1'b1));
    send(frame_of(24'(12345), 24'(-12345), 24'(99), 1'b0));
    drain();
    set_config(MODE_DECIMATE, 5'd2, 5'd3);
    send(frame_of(24'(8), 24'(-8), 24'(3), 1'b0));
    send(frame_of(24'(1), 24'(-1), 24'(-3), 1'b0));
    drain();

    // Factor above its range, and a write to the unused register index.
    set_config(MODE_REPEAT, 5'd31, 5'd6);
    send(frame_of(SMP_MIN, SMP_MAX, SMP_MIN, 1'b0));
    drain();
    write_reg(CFG_SPARE, 5'h1F);

    // Receiver held off while the input keeps coming.
    source_idle_pct = 0;
    sink_idle_pct   = 0;
    set_config(MODE_REPEAT, 5'd16, 5'd6);
    hold_requests <= hold_requests + 1;
    for (int i = 0; i < 8; i++) send(random_frame());
    drain();

    // Largest groups at full scale.
    sink_idle_pct = 20;
    set_config(MODE_DECIMATE, 5'd16, 5'd6);
    for (int i = 0; i < 16; i++) send(frame_of(SMP_MAX, SMP_MAX, SMP_MAX, 1'b0));
    for (int i = 0; i < 16; i++) send(frame_of(SMP_MIN, SMP_MIN, SMP_MIN, 1'b0));
    drain();

    random_sent = 65;
    while (random_sent < 250) begin
      case ($urandom_range(3))
        0: source_idle_pct = 0;
        1: source_idle_pct = 10;
        2: source_idle_pct = 30;
        default: source_idle_pct = 60;
      endcase
      case ($urandom_range(3))
        0: sink_idle_pct = 0;
        1: sink_idle_pct = 10;
        2: sink_idle_pct = 30;
        default: sink_idle_pct = 60;
      endcase
      if ($urandom_range(9) < 7) factor_v = CFG_DATA_BITS'($urandom_range(6, 2));
      else factor_v = CFG_DATA_BITS'($urandom_range(31));
      set_config(CFG_DATA_BITS'($urandom_range(31)), factor_v,
                 CFG_DATA_BITS'($urandom_range(31)));
      burst = $urandom_range(30, 8);
      for (int i = 0; i < burst; i++) send(random_frame());
      random_sent += burst;
      drain();
    end

    $display("Run covered %0d input frames over %0d register settings; %0d result frames checked.",
             frames_taken, settings_used, results_checked);
    $display("Averaged groups %0d, dropped partial groups %0d, repeated frames %0d.",
             groups_emitted, groups_dropped, frames_repeated);
    if (errors == 0 && expected_frames.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0t: %0d mismatches, %0d result frames never arrived", $time, errors,
               expected_frames.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pirs_pkg.sv
rtl/pirs_stream_if.sv
rtl/pirs_div.sv
rtl/pirs_dp.sv
rtl/pirs_ctrl.sv
rtl/pcm_integer_rate_scaler_core.sv
tb/tb_pcm_integer_rate_scaler_core.sv
